### hdl/tmc_pkg.sv
// Package for the trapezoid motion controller: opcodes, register indexes,
// controller states, datapath operations, CORDIC table and saturation helper.
// No dependencies.
package tmc_pkg;

  localparam logic [1:0] OPC_TICK  = 2'd0;
  localparam logic [1:0] OPC_DIST  = 2'd1;
  localparam logic [1:0] OPC_ANG   = 2'd2;
  localparam logic [1:0] OPC_SPARE = 2'd3;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_DBAND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_DBAND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE        = 3'd7;

  localparam logic [30:0] RST_SPEED_LIMIT = 31'd65536;
  localparam logic [30:0] RST_ACCEL_LIMIT = 31'd32768;
  localparam logic [30:0] RST_STEP_TIME   = 31'd1092;
  localparam logic [30:0] RST_DIST_DBAND  = 31'd1966;
  localparam logic [30:0] RST_ANGLE_DBAND = 31'd655;
  localparam logic [30:0] RST_ANGLE_GAIN  = 31'd196608;

  localparam logic [63:0] PHASE_SCALE = 64'h28BE60DB9391054A;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS = 32;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [4:0] {
    ST_IDLE, ST_ANG_MUL, ST_ANG_FIN, ST_SL_SQ, ST_ACC_D, ST_CMP, ST_RAMP,
    ST_SQRT_BR, ST_PH1, ST_PH2, ST_PH3, ST_CORDIC, ST_MUL_VX, ST_MUL_VY,
    ST_STORE_VY, ST_SQ_X, ST_SQ_Y, ST_SQ_SUM, ST_SQRT_LEN, ST_DIST_FIN
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_SET_DIST, OP_SET_ANG, OP_LOAD, OP_ANG_MUL, OP_FIN_A,
    OP_SL_SQ, OP_ACC_D, OP_CMP, OP_RAMP, OP_SQRT_BR, OP_PH1, OP_PH2, OP_PH3,
    OP_CORDIC, OP_MUL_VX, OP_MUL_VY, OP_STORE_VY, OP_SQ_X, OP_SQ_Y,
    OP_SQ_SUM, OP_SQRT_LEN, OP_FIN_D
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic angle_mode;
    logic dead;
    logic brake;
    logic last;
    logic out_free;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic hi_zero;
    logic hi_ones;
    hi_zero = (v[67:31] == '0);
    hi_ones = (v[67:31] == '1);
    if (hi_zero || hi_ones) begin
      return v[31:0];
    end else if (v[67]) begin
      return 32'sh80000000;
    end else begin
      return 32'sh7FFFFFFF;
    end
  endfunction

endpackage

### hdl/tmc_ctrl.sv
// Controller state machine of the trapezoid motion controller.
// Sequences datapath operations per request; uses tmc_pkg.
module tmc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  tmc_pkg::status_t     status_i,
  output tmc_pkg::cmd_t        cmd_o
);

  tmc_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmc_pkg::ST_IDLE: begin
        if (in_valid_i && opcode_i == tmc_pkg::OPC_TICK) begin
          state_d = status_i.angle_mode ? tmc_pkg::ST_ANG_MUL : tmc_pkg::ST_SL_SQ;
        end
      end
      tmc_pkg::ST_ANG_MUL:  state_d = tmc_pkg::ST_ANG_FIN;
      tmc_pkg::ST_ANG_FIN: begin
        if (status_i.out_free) state_d = tmc_pkg::ST_IDLE;
      end
      tmc_pkg::ST_SL_SQ:    state_d = tmc_pkg::ST_ACC_D;
      tmc_pkg::ST_ACC_D:    state_d = tmc_pkg::ST_CMP;
      tmc_pkg::ST_CMP:      state_d = tmc_pkg::ST_RAMP;
      tmc_pkg::ST_RAMP: begin
        state_d = (status_i.brake && !status_i.dead) ? tmc_pkg::ST_SQRT_BR : tmc_pkg::ST_PH1;
      end
      tmc_pkg::ST_SQRT_BR: begin
        if (status_i.last) state_d = tmc_pkg::ST_PH1;
      end
      tmc_pkg::ST_PH1:      state_d = tmc_pkg::ST_PH2;
      tmc_pkg::ST_PH2:      state_d = tmc_pkg::ST_PH3;
      tmc_pkg::ST_PH3:      state_d = tmc_pkg::ST_CORDIC;
      tmc_pkg::ST_CORDIC: begin
        if (status_i.last) state_d = tmc_pkg::ST_MUL_VX;
      end
      tmc_pkg::ST_MUL_VX:   state_d = tmc_pkg::ST_MUL_VY;
      tmc_pkg::ST_MUL_VY:   state_d = tmc_pkg::ST_STORE_VY;
      tmc_pkg::ST_STORE_VY: state_d = tmc_pkg::ST_SQ_X;
      tmc_pkg::ST_SQ_X:     state_d = tmc_pkg::ST_SQ_Y;
      tmc_pkg::ST_SQ_Y:     state_d = tmc_pkg::ST_SQ_SUM;
      tmc_pkg::ST_SQ_SUM:   state_d = tmc_pkg::ST_SQRT_LEN;
      tmc_pkg::ST_SQRT_LEN: begin
        if (status_i.last) state_d = tmc_pkg::ST_DIST_FIN;
      end
      tmc_pkg::ST_DIST_FIN: begin
        if (status_i.out_free) state_d = tmc_pkg::ST_IDLE;
      end
      default: state_d = tmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = tmc_pkg::OP_NONE;
    unique case (state_q)
      tmc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (opcode_i)
            tmc_pkg::OPC_TICK: cmd_o.op = tmc_pkg::OP_LOAD;
            tmc_pkg::OPC_DIST: cmd_o.op = tmc_pkg::OP_SET_DIST;
            tmc_pkg::OPC_ANG:  cmd_o.op = tmc_pkg::OP_SET_ANG;
            default:           cmd_o.op = tmc_pkg::OP_NONE;
          endcase
        end
      end
      tmc_pkg::ST_ANG_MUL:  cmd_o.op = tmc_pkg::OP_ANG_MUL;
      tmc_pkg::ST_ANG_FIN: begin
        // hold the product while the output register is full
        if (status_i.out_free) cmd_o.op = tmc_pkg::OP_FIN_A;
        else                   cmd_o.op = tmc_pkg::OP_ANG_MUL;
      end
      tmc_pkg::ST_SL_SQ:    cmd_o.op = tmc_pkg::OP_SL_SQ;
      tmc_pkg::ST_ACC_D:    cmd_o.op = tmc_pkg::OP_ACC_D;
      tmc_pkg::ST_CMP:      cmd_o.op = tmc_pkg::OP_CMP;
      tmc_pkg::ST_RAMP:     cmd_o.op = tmc_pkg::OP_RAMP;
      tmc_pkg::ST_SQRT_BR:  cmd_o.op = tmc_pkg::OP_SQRT_BR;
      tmc_pkg::ST_PH1:      cmd_o.op = tmc_pkg::OP_PH1;
      tmc_pkg::ST_PH2:      cmd_o.op = tmc_pkg::OP_PH2;
      tmc_pkg::ST_PH3:      cmd_o.op = tmc_pkg::OP_PH3;
      tmc_pkg::ST_CORDIC:   cmd_o.op = tmc_pkg::OP_CORDIC;
      tmc_pkg::ST_MUL_VX:   cmd_o.op = tmc_pkg::OP_MUL_VX;
      tmc_pkg::ST_MUL_VY:   cmd_o.op = tmc_pkg::OP_MUL_VY;
      tmc_pkg::ST_STORE_VY: cmd_o.op = tmc_pkg::OP_STORE_VY;
      tmc_pkg::ST_SQ_X:     cmd_o.op = tmc_pkg::OP_SQ_X;
      tmc_pkg::ST_SQ_Y:     cmd_o.op = tmc_pkg::OP_SQ_Y;
      tmc_pkg::ST_SQ_SUM:   cmd_o.op = tmc_pkg::OP_SQ_SUM;
      tmc_pkg::ST_SQRT_LEN: cmd_o.op = tmc_pkg::OP_SQRT_LEN;
      tmc_pkg::ST_DIST_FIN: begin
        if (status_i.out_free) cmd_o.op = tmc_pkg::OP_FIN_D;
      end
      default: cmd_o.op = tmc_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o = (state_q != tmc_pkg::ST_IDLE);

`ifndef NO_ASSERTIONS
  a_ang_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmc_pkg::ST_IDLE && in_valid_i && opcode_i == tmc_pkg::OPC_TICK
     && status_i.angle_mode) |=> (state_q == tmc_pkg::ST_ANG_MUL))
    else $error("angle tick did not start the angle sequence");
  a_cordic_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmc_pkg::ST_CORDIC && !status_i.last) |=> (state_q == tmc_pkg::ST_CORDIC))
    else $error("CORDIC left early");
  a_len_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmc_pkg::ST_SQRT_LEN && status_i.last) |=> (state_q == tmc_pkg::ST_DIST_FIN))
    else $error("step length root did not finish the tick");
`endif

endmodule

### hdl/tmc_dp.sv
// Datapath of the trapezoid motion controller: configuration and state registers,
// shared multiplier, iterative square root, CORDIC and output register; uses tmc_pkg.
module tmc_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tmc_pkg::cmd_t               cmd_i,
  output tmc_pkg::status_t            status_o,
  input  logic signed [31:0]          pos_x_i,
  input  logic signed [31:0]          pos_y_i,
  input  logic signed [31:0]          heading_i,
  input  logic signed [31:0]          command_value_i,
  input  logic                        cfg_we_i,
  input  logic [tmc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [30:0]                 cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        linear_valid_o,
  output logic signed [31:0]          vel_x_o,
  output logic signed [31:0]          vel_y_o,
  output logic                        angular_valid_o,
  output logic signed [31:0]          angular_vel_o
);

  localparam logic [63:0] COEF = tmc_pkg::PHASE_SCALE >> FRAC_BITS;

  logic [30:0] sl_q, acc_q, st_q, ddb_q, adb_q, gain_q;
  logic mode_q;
  logic signed [31:0] dleft_q, htgt_q, cspd_q, lx_q, ly_q, lh_q;
  logic signed [31:0] px_q, py_q, hd_q;
  logic signed [67:0] prod_q;
  logic [63:0] t_q;
  logic dead_q, brake_q;
  logic [30:0] sp_q;
  logic [31:0] phl_q;
  logic flip_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [32:0] cz_q;
  logic [4:0] iter_q;
  logic [63:0] sqn_q, sqr_q;
  logic signed [31:0] vx_q, vy_q;
  logic ov_q, olin_q, oang_q;
  logic signed [31:0] ovx_q, ovy_q, ow_q;

  logic signed [33:0] mul_a, mul_b;
  logic [31:0] ad;
  logic sg_pos, sg_neg;
  logic signed [31:0] spd;
  logic [5:0] shamt;
  logic [63:0] sq_bit, sq_sum, r_next, n_next;
  logic sq_ge;
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;
  logic signed [32:0] dx, dy, err;
  logic [32:0] ax33, ay33, ae;
  logic big;
  logic [31:0] axh, ayh;
  logic [32:0] len;
  logic signed [34:0] dext, lext, newd;
  logic [63:0] inc, ramp;
  logic [31:0] prev;
  logic [30:0] ramp_sp;
  logic [31:0] ph, php;
  logic fl;
  logic signed [33:0] cs, sn;
  logic fin;
  logic signed [67:0] w_sh, v_sh;

  assign fin = (cmd_i.op == tmc_pkg::OP_FIN_D) || (cmd_i.op == tmc_pkg::OP_FIN_A);

  always_comb begin
    ad     = dleft_q[31] ? (32'd0 - dleft_q) : dleft_q;
    sg_neg = dleft_q[31];
    sg_pos = !dleft_q[31] && (dleft_q != 32'sd0);
    if (sg_pos)      spd = $signed({1'b0, sp_q});
    else if (sg_neg) spd = -$signed({1'b0, sp_q});
    else             spd = 32'sd0;

    shamt  = 6'd62 - {iter_q, 1'b0};
    sq_bit = 64'd1 << shamt;
    sq_sum = sqr_q + sq_bit;
    sq_ge  = (sqn_q >= sq_sum);
    r_next = sq_ge ? ((sqr_q >> 1) + sq_bit) : (sqr_q >> 1);
    n_next = sq_ge ? (sqn_q - sq_sum) : sqn_q;

    xs = cy_q >>> iter_q;
    ys = cx_q >>> iter_q;
    at = $signed({1'b0, tmc_pkg::ATAN_TURNS[iter_q]});

    dx   = {px_q[31], px_q} - {lx_q[31], lx_q};
    dy   = {py_q[31], py_q} - {ly_q[31], ly_q};
    ax33 = dx[32] ? (33'd0 - dx) : dx;
    ay33 = dy[32] ? (33'd0 - dy) : dy;
    big  = ax33[32] | ax33[31] | ay33[32] | ay33[31];
    axh  = big ? ax33[32:1] : ax33[31:0];
    ayh  = big ? ay33[32:1] : ay33[31:0];
    len  = big ? {sqr_q[31:0], 1'b0} : {1'b0, sqr_q[31:0]};
    dext = {{3{dleft_q[31]}}, dleft_q};
    lext = $signed({2'b0, len});
    if (sg_pos)      newd = dext - lext;
    else if (sg_neg) newd = dext + lext;
    else             newd = dext;

    err = {htgt_q[31], htgt_q} - {hd_q[31], hd_q};
    ae  = err[32] ? (33'd0 - err) : err;

    inc     = prod_q[63:0] >> FRAC_BITS;
    prev    = cspd_q[31] ? (32'd0 - cspd_q) : cspd_q;
    ramp    = {32'd0, prev} + inc;
    ramp_sp = (ramp < {33'd0, sl_q}) ? ramp[30:0] : sl_q;

    ph   = phl_q + prod_q[31:0];
    fl   = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
    php  = ph + (fl ? 32'h80000000 : 32'h0);

    cs = flip_q ? -cx_q : cx_q;
    sn = flip_q ? -cy_q : cy_q;

    v_sh = prod_q >>> 30;
    w_sh = prod_q >>> FRAC_BITS;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      tmc_pkg::OP_SL_SQ:  begin mul_a = {3'b0, sl_q};  mul_b = {3'b0, sl_q}; end
      tmc_pkg::OP_ACC_D:  begin mul_a = {3'b0, acc_q}; mul_b = {2'b0, ad}; end
      tmc_pkg::OP_CMP:    begin mul_a = {3'b0, st_q};  mul_b = {3'b0, acc_q}; end
      tmc_pkg::OP_PH1:    begin mul_a = {{2{lh_q[31]}}, lh_q}; mul_b = {2'b0, COEF[31:0]}; end
      tmc_pkg::OP_PH2:    begin mul_a = {{2{lh_q[31]}}, lh_q}; mul_b = {2'b0, COEF[63:32]}; end
      tmc_pkg::OP_MUL_VX: begin mul_a = {{2{spd[31]}}, spd}; mul_b = cs; end
      tmc_pkg::OP_MUL_VY: begin mul_a = {{2{spd[31]}}, spd}; mul_b = sn; end
      tmc_pkg::OP_SQ_X:   begin mul_a = {2'b0, axh}; mul_b = {2'b0, axh}; end
      tmc_pkg::OP_SQ_Y:   begin mul_a = {2'b0, ayh}; mul_b = {2'b0, ayh}; end
      tmc_pkg::OP_ANG_MUL: begin mul_a = {err[32], err}; mul_b = {3'b0, gain_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sl_q   <= tmc_pkg::RST_SPEED_LIMIT;
      acc_q  <= tmc_pkg::RST_ACCEL_LIMIT;
      st_q   <= tmc_pkg::RST_STEP_TIME;
      ddb_q  <= tmc_pkg::RST_DIST_DBAND;
      adb_q  <= tmc_pkg::RST_ANGLE_DBAND;
      gain_q <= tmc_pkg::RST_ANGLE_GAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tmc_pkg::CFG_SPEED_LIMIT: sl_q   <= cfg_data_i;
        tmc_pkg::CFG_ACCEL_LIMIT: acc_q  <= cfg_data_i;
        tmc_pkg::CFG_STEP_TIME:   st_q   <= cfg_data_i;
        tmc_pkg::CFG_DIST_DBAND:  ddb_q  <= cfg_data_i;
        tmc_pkg::CFG_ANGLE_DBAND: adb_q  <= cfg_data_i;
        tmc_pkg::CFG_ANGLE_GAIN:  gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      dleft_q <= '0;
      htgt_q  <= '0;
      cspd_q  <= '0;
      lx_q    <= '0;
      ly_q    <= '0;
      lh_q    <= '0;
      ov_q    <= 1'b0;
      iter_q  <= '0;
    end else begin
      if (fin) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
      case (cmd_i.op)
        tmc_pkg::OP_SET_DIST: begin
          mode_q  <= 1'b0;
          dleft_q <= command_value_i;
        end
        tmc_pkg::OP_SET_ANG: begin
          mode_q <= 1'b1;
          htgt_q <= tmc_pkg::sat32({{36{command_value_i[31]}}, command_value_i}
                                   + {{36{lh_q[31]}}, lh_q});
        end
        tmc_pkg::OP_CMP, tmc_pkg::OP_PH3, tmc_pkg::OP_SQ_SUM: iter_q <= '0;
        tmc_pkg::OP_SQRT_BR, tmc_pkg::OP_SQRT_LEN, tmc_pkg::OP_CORDIC:
          iter_q <= iter_q + 5'd1;
        tmc_pkg::OP_FIN_D: begin
          dleft_q <= tmc_pkg::sat32({{33{newd[34]}}, newd});
          cspd_q  <= spd;
          lx_q    <= px_q;
          ly_q    <= py_q;
          lh_q    <= hd_q;
        end
        tmc_pkg::OP_FIN_A: begin
          lx_q <= px_q;
          ly_q <= py_q;
          lh_q <= hd_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      tmc_pkg::OP_LOAD: begin
        px_q <= pos_x_i;
        py_q <= pos_y_i;
        hd_q <= heading_i;
      end
      tmc_pkg::OP_ACC_D, tmc_pkg::OP_SQ_Y: t_q <= prod_q[63:0];
      tmc_pkg::OP_CMP: begin
        brake_q <= ({prod_q[62:0], 1'b0} < t_q);
        dead_q  <= (ad < {1'b0, ddb_q});
        sqn_q   <= {prod_q[62:0], 1'b0};
        sqr_q   <= '0;
      end
      tmc_pkg::OP_RAMP: sp_q <= dead_q ? 31'd0 : ramp_sp;
      tmc_pkg::OP_SQRT_BR: begin
        sqn_q <= n_next;
        sqr_q <= r_next;
        if (iter_q == 5'(tmc_pkg::SQRT_STEPS - 1)) sp_q <= r_next[30:0];
      end
      tmc_pkg::OP_SQRT_LEN: begin
        sqn_q <= n_next;
        sqr_q <= r_next;
      end
      tmc_pkg::OP_PH2: phl_q <= prod_q[63:32];
      tmc_pkg::OP_PH3: begin
        flip_q <= fl;
        cx_q   <= tmc_pkg::CORDIC_GAIN;
        cy_q   <= '0;
        cz_q   <= {php[31], php};
      end
      tmc_pkg::OP_CORDIC: begin
        if (!cz_q[32]) begin
          cx_q <= cx_q - xs;
          cy_q <= cy_q + ys;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + xs;
          cy_q <= cy_q - ys;
          cz_q <= cz_q + at;
        end
      end
      tmc_pkg::OP_MUL_VY:   vx_q <= tmc_pkg::sat32(v_sh);
      tmc_pkg::OP_STORE_VY: vy_q <= tmc_pkg::sat32(v_sh);
      tmc_pkg::OP_SQ_SUM: begin
        sqn_q <= t_q + prod_q[63:0];
        sqr_q <= '0;
      end
      tmc_pkg::OP_FIN_D: begin
        olin_q <= 1'b1;
        ovx_q  <= vx_q;
        ovy_q  <= vy_q;
        oang_q <= 1'b0;
        ow_q   <= '0;
      end
      tmc_pkg::OP_FIN_A: begin
        olin_q <= 1'b0;
        ovx_q  <= '0;
        ovy_q  <= '0;
        oang_q <= (ae > {2'b0, adb_q});
        ow_q   <= (ae > {2'b0, adb_q}) ? tmc_pkg::sat32(w_sh) : 32'sd0;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.angle_mode = mode_q;
    status_o.dead       = dead_q;
    status_o.brake      = brake_q;
    status_o.last       = ((cmd_i.op == tmc_pkg::OP_SQRT_BR || cmd_i.op == tmc_pkg::OP_SQRT_LEN)
                           && iter_q == 5'(tmc_pkg::SQRT_STEPS - 1))
                          || (cmd_i.op == tmc_pkg::OP_CORDIC
                              && iter_q == 5'(tmc_pkg::CORDIC_STEPS - 1));
    status_o.out_free   = !ov_q || !out_stall_i;
  end

  assign out_valid_o     = ov_q;
  assign linear_valid_o  = olin_q;
  assign vel_x_o         = ovx_q;
  assign vel_y_o         = ovy_q;
  assign angular_valid_o = oang_q;
  assign angular_vel_o   = ow_q;

`ifndef NO_ASSERTIONS
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == tmc_pkg::OP_FIN_D || cmd_i.op == tmc_pkg::OP_FIN_A) |-> (!ov_q || !out_stall_i))
    else $error("result written over a held result");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(ovx_q) && $stable(ovy_q) && $stable(ow_q)))
    else $error("stalled result changed");
  a_ang_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == tmc_pkg::OP_SET_ANG) |=> mode_q)
    else $error("angle command did not select angle mode");
`endif

endmodule

### hdl/trapezoid_motion_controller_top.sv
// Top level of the trapezoid motion controller: joins controller and datapath.
// Depends on tmc_pkg, tmc_ctrl and tmc_dp.
//
// An angle-mode tick multiplies the heading error by the angle gain. A distance-mode
// tick takes the braking-zone square root only when braking outside the dead band; the
// 24-step CORDIC and the 32-step bit-by-bit square root share one sequencer with a
// single registered 34x34 multiplier. Requests are accepted only while idle; a
// finished result waits in the output register while the next request comes in.
module trapezoid_motion_controller_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic signed [31:0]            pos_x_i,
  input  logic signed [31:0]            pos_y_i,
  input  logic signed [31:0]            heading_i,
  input  logic signed [31:0]            command_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          linear_valid_o,
  output logic signed [31:0]            vel_x_o,
  output logic signed [31:0]            vel_y_o,
  output logic                          angular_valid_o,
  output logic signed [31:0]            angular_vel_o,
  input  logic                          cfg_we_i,
  input  logic [tmc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [30:0]                   cfg_data_i
);

  tmc_pkg::cmd_t    cmd;
  tmc_pkg::status_t status;

  tmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tmc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .heading_i       (heading_i),
    .command_value_i (command_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .linear_valid_o  (linear_valid_o),
    .vel_x_o         (vel_x_o),
    .vel_y_o         (vel_y_o),
    .angular_valid_o (angular_valid_o),
    .angular_vel_o   (angular_vel_o)
  );

endmodule
